/* design/knn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package knn_pkg;
  localparam int MaxPoints = 4096;
  localparam int MaxK = 32;
  localparam int AddrW = $clog2(MaxPoints);
  localparam int CntW = $clog2(MaxPoints + 1);
  localparam int KIdxW = $clog2(MaxK);
  localparam int KW = $clog2(MaxK + 1);
  localparam int DistW = 35;
  localparam int WSumW = 38;

  typedef enum logic [1:0] {
    CMD_STORE = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_VOTED = 3'd0,
    ST_ZERO  = 3'd1,
    ST_FEW   = 3'd2,
    ST_FULL  = 3'd3,
    ST_DONE  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_DIST,
    S_SCAN_INS,
    S_SHIFT,
    S_DIV_START,
    S_DIV,
    S_ACC,
    S_FINISH,
    S_OUT
  } state_t;

  localparam logic REG_K = 1'b0;
  localparam logic REG_ZW = 1'b1;
endpackage
`default_nettype wire

/* design/knn_inverse_distance_classifier_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Weighted-vote k-nearest-neighbour classifier over labelled 3-D points.
// Input items arrive on s_axis (tvalid/tready/tdata); each produces exactly one
// result item on m_axis. A store, clear or skipped item passes through FINISH to
// OUT after it is accepted, and the block returns to IDLE to accept the next item
// once that result is taken.
// A query reads the point store through a single memory port. Each stored point passes
// through a read, a distance and an insertion state, then a shift state that runs again
// for every place it moves up the neighbour list. The K inverse-distance weights
// then come from one shared restoring divider of 33 quotient bits, one bit per cycle.
// After the last neighbour's weight is added in ACC, the query passes through FINISH to OUT.
// Only one item is in work at a time: s_axis_tready is high only when idle.
// The result is held in an output register until taken; while the receiver
// stalls, no new item is accepted.
// Configuration is written on cfg_we/cfg_index/cfg_data, index 0 for the
// neighbour count K and index 1 for the zero-distance weight.
// A synchronous active-high reset empties the store (stored count zero),
// clears the vote counters and restores K = 5 and the weight 256000000.
// The store memory itself is not cleared; only entries below the count are read.
module knn_inverse_distance_classifier_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: command[1:0], coord_x[17:2], coord_y[33:18], coord_z[49:34],
  // point_class[50], zero fill to 56 bits
  input  wire logic [55:0] s_axis_tdata,
  // tlast: last_of_cloud
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: status[2:0], point_vote[3], class0_votes[19:4], class1_votes[35:20],
  // cloud_class[36], zero fill to 40 bits
  output logic [39:0]      m_axis_tdata,
  // tlast: cloud_done
  output logic             m_axis_tlast
);
  import knn_pkg::*;

  state_t state, state_next;

  logic [5:0]  kreg;
  logic [31:0] zw;
  logic [CntW-1:0] stored_count;
  logic [15:0] votes_zero, votes_one;

  // Captured item
  logic [1:0] cmd;
  logic signed [15:0] qx, qy, qz;
  logic qlast;

  // Memory
  logic [48:0] mem [MaxPoints];
  logic [48:0] rd_data;
  logic [AddrW-1:0] rd_addr;
  logic [CntW-1:0] idx;

  // Neighbour list
  logic [DistW-1:0] bd [MaxK];
  logic bc [MaxK];
  logic [KW-1:0] n, k_eff;
  logic [KIdxW-1:0] j;
  logic [DistW-1:0] cur_d;
  logic cur_c;

  // Divider
  logic [DistW-1:0] dvs, quo;
  logic [DistW:0] rem;
  logic [32:0] dvd;
  logic [5:0] dcnt;
  logic [WSumW-1:0] w0, w1;

  logic [2:0] o_status;
  logic o_vote, o_done, o_class;

  always_comb begin
    if (kreg == 6'd0) k_eff = KW'(1);
    else if (kreg > 6'(MaxK)) k_eff = KW'(MaxK);
    else k_eff = KW'(kreg);
  end

  logic signed [17:0] in_sum;
  always_comb in_sum = 18'(signed'(qx)) + 18'(signed'(qy)) + 18'(signed'(qz));
  logic zero_pt;
  assign zero_pt = (in_sum == 18'sd0);

  // Squared distance of the registered store entry to the query
  logic signed [16:0] dx, dy, dz;
  logic [33:0] sx, sy, sz;
  always_comb begin
    dx = 17'(qx) - 17'(signed'(rd_data[15:0]));
    dy = 17'(qy) - 17'(signed'(rd_data[31:16]));
    dz = 17'(qz) - 17'(signed'(rd_data[47:32]));
    sx = 34'(dx * dx);
    sy = 34'(dy * dy);
    sz = 34'(dz * dz);
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_axis_tvalid && cmd_t'(s_axis_tdata[1:0]) == CMD_STORE
        && stored_count < CntW'(MaxPoints))
      mem[stored_count[AddrW-1:0]] <= s_axis_tdata[50:2];
    rd_data <= mem[rd_addr];
  end
  assign rd_addr = idx[AddrW-1:0];

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata = {3'd0, o_class, votes_one, votes_zero, o_vote, o_status};
  assign m_axis_tlast = o_done;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (s_axis_tvalid) state_next = S_FINISH;
      S_SCAN_RD: state_next = (idx == stored_count) ? S_DIV_START : S_SCAN_DIST;
      S_SCAN_DIST: state_next = S_SCAN_INS;
      S_SCAN_INS: state_next = S_SHIFT;
      S_SHIFT: if (j == '0 || !(bd[j - KIdxW'(1)] > cur_d)) state_next = S_SCAN_RD;
      S_DIV_START: state_next = S_DIV;
      S_DIV: if (dcnt == 6'd0) state_next = S_ACC;
      S_ACC: state_next = (KW'(j) == n - KW'(1)) ? S_FINISH : S_DIV_START;
      S_FINISH: state_next = S_OUT;
      S_OUT: if (m_axis_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    // A query that goes to scan leaves FINISH for SCAN_RD instead of OUT.
    if (state == S_FINISH && cmd_t'(cmd) == CMD_QUERY && o_status == 3'(ST_VOTED)
        && n == '0 && !o_done && !zero_pt && stored_count >= CntW'(k_eff))
      state_next = S_SCAN_RD;
  end

  logic skip;
  assign skip = (n == k_eff) && (cur_d >= bd[k_eff[KIdxW-1:0] - KIdxW'(1)]);

  always_ff @(posedge clk) begin
    if (rst) begin
      kreg <= 6'd5;
      zw <= 32'd256000000;
      stored_count <= '0;
      votes_zero <= '0;
      votes_one <= '0;
      o_done <= 1'b0;
      n <= '0;
    end else begin
      if (cfg_we && state == S_IDLE) begin
        if (cfg_index == REG_K) kreg <= cfg_data[5:0];
        else zw <= cfg_data;
      end
      unique case (state)
        S_IDLE: if (s_axis_tvalid) begin
          cmd <= s_axis_tdata[1:0];
          qx <= s_axis_tdata[17:2];
          qy <= s_axis_tdata[33:18];
          qz <= s_axis_tdata[49:34];
          qlast <= s_axis_tlast;
          o_status <= 3'(ST_VOTED);
          o_done <= 1'b0;
          n <= '0;
          idx <= '0;
          j <= '0;
        end
        S_FINISH: begin
          if (n == '0 && !o_done && o_status == 3'(ST_VOTED)) begin
            // First pass: decode the command.
            o_vote <= 1'b0;
            o_class <= 1'b0;
            unique case (cmd_t'(cmd))
              CMD_STORE: begin
                if (zero_pt) o_status <= 3'(ST_ZERO);
                else if (stored_count >= CntW'(MaxPoints)) o_status <= 3'(ST_FULL);
                else begin
                  stored_count <= stored_count + 1'b1;
                  o_status <= 3'(ST_DONE);
                end
              end
              CMD_CLEAR: begin
                stored_count <= '0;
                o_status <= 3'(ST_DONE);
              end
              CMD_NONE: o_status <= 3'(ST_DONE);
              CMD_QUERY: begin
                if (zero_pt) o_status <= 3'(ST_ZERO);
                else if (stored_count < CntW'(k_eff)) o_status <= 3'(ST_FEW);
                if (zero_pt || stored_count < CntW'(k_eff)) begin
                  if (qlast) begin
                    o_done <= 1'b1;
                    o_class <= (votes_zero > votes_one) ? 1'b0 : 1'b1;
                  end
                end else begin
                  w0 <= '0;
                  w1 <= '0;
                end
              end
              default: ;
            endcase
          end else begin
            // End of a query's vote.
            o_vote <= (w1 < w0) ? 1'b0 : 1'b1;
            if (w1 < w0) begin
              if (votes_zero != 16'hFFFF) votes_zero <= votes_zero + 1'b1;
            end else if (votes_one != 16'hFFFF) votes_one <= votes_one + 1'b1;
            if (qlast) begin
              o_done <= 1'b1;
              o_class <= (((w1 < w0) && votes_zero != 16'hFFFF ? votes_zero + 1'b1
                          : votes_zero) > ((!(w1 < w0)) && votes_one != 16'hFFFF
                          ? votes_one + 1'b1 : votes_one)) ? 1'b0 : 1'b1;
            end
          end
        end
        S_SCAN_RD: ;
        S_SCAN_DIST: begin
          cur_d <= DistW'(sx) + DistW'(sy) + DistW'(sz);
          cur_c <= rd_data[48];
          idx <= idx + 1'b1;
        end
        S_SCAN_INS: begin
          if (skip) j <= '0;
          else if (n < k_eff) begin
            j <= n[KIdxW-1:0];
            n <= n + 1'b1;
          end else j <= k_eff[KIdxW-1:0] - KIdxW'(1);
          if (skip) cur_d <= '1;
        end
        S_SHIFT: begin
          if (cur_d == '1 && j == '0) ;
          else if (j != '0 && bd[j - KIdxW'(1)] > cur_d) begin
            bd[j] <= bd[j - KIdxW'(1)];
            bc[j] <= bc[j - KIdxW'(1)];
            j <= j - 1'b1;
          end else begin
            bd[j] <= cur_d;
            bc[j] <= cur_c;
            j <= '0;
          end
        end
        S_DIV_START: begin
          dvs <= bd[j];
          rem <= '0;
          quo <= '0;
          dvd <= 33'h1_0000_0000;
          dcnt <= 6'd32;
        end
        S_DIV: begin
          logic [DistW:0] r2;
          r2 = {rem[DistW-1:0], dvd[32]};
          dvd <= {dvd[31:0], 1'b0};
          if (r2 >= {1'b0, dvs}) begin
            rem <= r2 - {1'b0, dvs};
            quo <= {quo[DistW-2:0], 1'b1};
          end else begin
            rem <= r2;
            quo <= {quo[DistW-2:0], 1'b0};
          end
          dcnt <= dcnt - 1'b1;
        end
        S_ACC: begin
          if (bc[j] == 1'b0)
            w0 <= w0 + ((dvs == '0) ? WSumW'(zw) : WSumW'(quo));
          else
            w1 <= w1 + ((dvs == '0) ? WSumW'(zw) : WSumW'(quo));
          j <= j + 1'b1;
        end
        S_OUT: if (m_axis_tready && o_done) begin
          votes_zero <= '0;
          votes_one <= '0;
        end
        default: ;
      endcase
    end
  end

  // Scan insertion: a dropped candidate is marked all-ones and never stored.
  // The sentinel cannot be a real distance (at most 3*2^32).

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    stored_count <= CntW'(MaxPoints)) else $error("store count overflow");
  a_list_bound: assert property (@(posedge clk) disable iff (rst)
    n <= KW'(MaxK)) else $error("neighbour list overflow");
endmodule
`default_nettype wire

/* test/knn_vote_checker.sv */
`timescale 1ns / 1ps
module knn_vote_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [55:0] in_data,
  input  wire logic        in_last,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [39:0] out_data,
  input  wire logic        out_last,
  output int               fail_count,
  output int               pending_count
);
  import knn_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic        vote;
    logic [15:0] c0;
    logic [15:0] c1;
    logic        done;
    logic        cls;
  } verdict_t;

  logic signed [31:0] px [MaxPoints];
  logic signed [31:0] py [MaxPoints];
  logic signed [31:0] pz [MaxPoints];
  logic               pc [MaxPoints];
  int unsigned npts;
  int unsigned tally0, tally1;
  logic [5:0]  k_reg;
  logic [31:0] zero_weight;
  verdict_t    awaited[$];

  function automatic verdict_t classify_item(input logic [55:0] d, input logic lst);
    verdict_t v;
    logic [1:0] op;
    logic signed [31:0] x, y, z;
    logic [63:0] bd [MaxK];
    logic        bc [MaxK];
    logic [63:0] dd, w, w0, w1, ex, ey, ez;
    int unsigned k, n, j;
    bit zero;
    v = '0;
    op = d[1:0];
    x = $signed(d[17:2]);
    y = $signed(d[33:18]);
    z = $signed(d[49:34]);
    zero = (x + y + z) == 0;
    v.status = ST_DONE;
    if (op == CMD_STORE) begin
      if (zero) v.status = ST_ZERO;
      else if (npts >= MaxPoints) v.status = ST_FULL;
      else begin
        px[npts] = x; py[npts] = y; pz[npts] = z; pc[npts] = d[50];
        npts++;
      end
    end else if (op == CMD_CLEAR) begin
      npts = 0;
    end else if (op == CMD_QUERY) begin
      k = (k_reg == 0) ? 1 : (k_reg > MaxK ? MaxK : k_reg);
      if (zero) v.status = ST_ZERO;
      else if (npts < k) v.status = ST_FEW;
      else begin
        n = 0;
        for (int i = 0; i < npts; i++) begin
          ex = 64'(x - px[i]); ey = 64'(y - py[i]); ez = 64'(z - pz[i]);
          ex = (x < px[i]) ? -ex : ex;
          ey = (y < py[i]) ? -ey : ey;
          ez = (z < pz[i]) ? -ez : ez;
          dd = ex * ex + ey * ey + ez * ez;
          if (n == k && dd >= bd[k-1]) continue;
          if (n < k) begin j = n; n++; end else j = k - 1;
          while (j > 0 && bd[j-1] > dd) begin
            bd[j] = bd[j-1]; bc[j] = bc[j-1]; j--;
          end
          bd[j] = dd; bc[j] = pc[i];
        end
        w0 = 0; w1 = 0;
        for (int i = 0; i < n; i++) begin
          w = (bd[i] != 0) ? (64'd1 << 32) / bd[i] : 64'(zero_weight);
          if (bc[i]) w1 += w; else w0 += w;
        end
        v.vote = !(w1 < w0);
        if (v.vote) begin if (tally1 < 65535) tally1++; end
        else if (tally0 < 65535) tally0++;
        v.status = ST_VOTED;
      end
      if (lst) begin
        v.done = 1'b1;
        v.cls = !(tally0 > tally1);
      end
    end
    v.c0 = tally0[15:0];
    v.c1 = tally1[15:0];
    if (v.done) begin tally0 = 0; tally1 = 0; end
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      npts = 0; tally0 = 0; tally1 = 0; k_reg = 6'd5; zero_weight = 32'd256000000;
      fail_count = 0;
      awaited.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_K) k_reg = cfg_data[5:0];
        else zero_weight = cfg_data;
      end
      // The result is taken before a new item is predicted; only one is in work.
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          $error("result item with nothing expected: %h", out_data);
          fail_count++;
        end else begin
          want = awaited.pop_front();
          if (out_data[2:0] != want.status) begin
            $error("status expected %0d actual %0d", want.status, out_data[2:0]);
            fail_count++;
          end
          if (out_data[3] != want.vote) begin
            $error("point_vote expected %0d actual %0d", want.vote, out_data[3]);
            fail_count++;
          end
          if (out_data[19:4] != want.c0) begin
            $error("class0_votes expected %0d actual %0d", want.c0, out_data[19:4]);
            fail_count++;
          end
          if (out_data[35:20] != want.c1) begin
            $error("class1_votes expected %0d actual %0d", want.c1, out_data[35:20]);
            fail_count++;
          end
          if (out_last != want.done) begin
            $error("cloud_done expected %0d actual %0d", want.done, out_last);
            fail_count++;
          end
          if (out_data[36] != want.cls) begin
            $error("cloud_class expected %0d actual %0d", want.cls, out_data[36]);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) awaited = {awaited, classify_item(in_data, in_last)};
    end
    pending_count = awaited.size();
  end
endmodule

/* test/knn_inverse_distance_classifier_unit_tb.sv */
`timescale 1ns / 1ps
module knn_inverse_distance_classifier_unit_tb;
  import knn_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic m_axis_tlast;
  int fail_count, pending_count;

  // Idle percentages for each side, and the receiver hold-off request.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_recv = 1'b0;

  always #1 clk = ~clk;

  knn_inverse_distance_classifier_unit uut (.*);

  knn_vote_checker checker_i (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
    .in_last(s_axis_tlast), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_data(m_axis_tdata), .out_last(m_axis_tlast),
    .fail_count, .pending_count
  );

  // The receiver stalls at random, or holds off entirely while asked to.
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
  end

  // Offers one item and waits until the block takes it. Gaps go in before the item.
  // tvalid is left high after the handshake; the next item replaces it or the drain drops it.
  task automatic send_item(input cmd_t op, input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] z, input logic cls, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, cls, z, y, x, op};
    s_axis_tlast <= lst;
    do @(posedge clk); while (!(s_axis_tready && s_axis_tvalid));
  endtask

  // Waits until every result has come back, then lets the block settle.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Coordinates mostly near a few cluster centres, so distances stay varied.
  function automatic logic [15:0] near_coord(input int centre);
    return 16'(centre + $signed($urandom_range(4000)) - 2000);
  endfunction

  // One cloud: a few labelled points around two centres, then several queries.
  task automatic random_cloud;
    int ca, cb, nq;
    ca = $signed($urandom_range(20000)) - 10000;
    cb = $signed($urandom_range(20000)) - 10000;
    if ($urandom_range(3) == 0) send_item(CMD_CLEAR, '0, '0, '0, 1'b0, 1'b0);
    repeat ($urandom_range(8, 4)) begin
      if ($urandom_range(1))
        send_item(CMD_STORE, near_coord(ca), near_coord(ca), near_coord(ca), 1'b0, 1'b0);
      else
        send_item(CMD_STORE, near_coord(cb), near_coord(cb), near_coord(cb), 1'b1, 1'b0);
    end
    nq = $urandom_range(5, 2);
    for (int q = 0; q < nq; q++) begin
      case ($urandom_range(9))
        0: send_item(cmd_t'($urandom_range(3)), 16'($urandom), 16'($urandom),
                     16'($urandom), 1'($urandom), 1'($urandom));
        1: send_item(CMD_QUERY, 16'h0100, 16'hff00, 16'h0000, 1'($urandom), q == nq - 1);
        default: send_item(CMD_QUERY, near_coord(ca), near_coord(cb),
                           near_coord($urandom_range(1) ? ca : cb), 1'($urandom),
                           q == nq - 1);
      endcase
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty-store cases with the reset settings first.
    send_item(CMD_QUERY, 16'h0001, 16'h0000, 16'h0000, 1'b0, 1'b0);   // too few stored
    send_item(CMD_QUERY, 16'h1000, 16'hf000, 16'h0000, 1'b0, 1'b1);   // zero point, cloud end
    send_item(CMD_STORE, 16'h0003, 16'hfffd, 16'h0000, 1'b1, 1'b0);   // zero point skipped
    send_item(CMD_NONE, 16'hffff, 16'hffff, 16'hffff, 1'b1, 1'b1);    // changes nothing
    send_item(CMD_STORE, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0, 1'b0);
    send_item(CMD_STORE, 16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b0);
    send_item(CMD_STORE, 16'h0001, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_item(CMD_STORE, 16'h0001, 16'h0000, 16'h0000, 1'b1, 1'b0);   // tie with the last
    send_item(CMD_STORE, 16'h7fff, 16'h8000, 16'h8000, 1'b1, 1'b0);
    send_item(CMD_QUERY, 16'h0001, 16'h0000, 16'h0000, 1'b0, 1'b0);   // zero distance
    send_item(CMD_QUERY, 16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b0);   // largest distance
    send_item(CMD_QUERY, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0, 1'b1);
    drain();

    // K of one with the largest and the smallest zero-distance weight.
    write_reg(REG_K, 32'd1);
    write_reg(REG_ZW, 32'hffffffff);
    send_item(CMD_QUERY, 16'h0001, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_item(CMD_QUERY, 16'h0002, 16'h0000, 16'h0000, 1'b0, 1'b1);
    drain();
    write_reg(REG_K, 32'd0);   // acts as one
    write_reg(REG_ZW, 32'd0);
    send_item(CMD_QUERY, 16'h0001, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_item(CMD_CLEAR, '0, '0, '0, 1'b0, 1'b0);                     // counters are kept
    send_item(CMD_QUERY, 16'h0001, 16'h0000, 16'h0000, 1'b0, 1'b1);
    drain();

    // Random phase one: the receiver stalls the most, with K above the store size.
    write_reg(REG_K, 32'd63);
    write_reg(REG_ZW, 32'd256000000);
    send_idle_pct = 10;
    recv_idle_pct = 51;
    repeat (2) random_cloud();
    drain();

    write_reg(REG_K, 32'd3);
    repeat (4) random_cloud();
    drain();

    // Phase two: the sender idles the most; a long receiver hold-off fills the block.
    write_reg(REG_K, 32'd2);
    write_reg(REG_ZW, $urandom);
    send_idle_pct = 51;
    recv_idle_pct = 10;
    fork
      begin
        hold_recv = 1'b1;
        repeat (300) @(posedge clk);
        hold_recv = 1'b0;
      end
      repeat (3) random_cloud();
    join
    drain();

    // Phase three: neither side idles.
    write_reg(REG_K, 32'd5);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (4) random_cloud();
    drain();

    if (fail_count == 0) $display("knn_inverse_distance_classifier_unit verification clean");
    else $display("knn_inverse_distance_classifier_unit verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("knn_inverse_distance_classifier_unit verification failed");
    $finish;
  end
endmodule

/* filelist.f */
design/knn_pkg.sv
design/knn_inverse_distance_classifier_unit.sv
test/knn_vote_checker.sv
test/knn_inverse_distance_classifier_unit_tb.sv
